### rtl/prc_pkg.sv
`default_nettype none

package prc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ADDR_WIDTH_DEF  = 64;
    localparam int MARKS_W         = 3;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_LOOKUP = 2'd3
    } t_cmd;

    // Outcome of comparing one table entry against the walk cursor
    typedef struct packed {
        logic start_above;  // entry start > cursor
        logic end_le_cur;   // entry end <= cursor
        logic end_lt_stop;  // entry end < stop
        logic marks_ok;     // entry carries every required mark
    } t_cmp;

endpackage

`default_nettype wire

### rtl/prc_ram.sv
`default_nettype none

module prc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/prc_cmp.sv
`default_nettype none

module prc_cmp #(
    parameter int ADDR_WIDTH = prc_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic [ADDR_WIDTH-1:0]      i_ent_start,
    input  wire logic [ADDR_WIDTH-1:0]      i_ent_end,
    input  wire logic [prc_pkg::MARKS_W-1:0] i_ent_marks,
    input  wire logic [ADDR_WIDTH-1:0]      i_cur,
    input  wire logic [ADDR_WIDTH-1:0]      i_stop,
    input  wire logic [prc_pkg::MARKS_W-1:0] i_need,
    output prc_pkg::t_cmp                   o_cmp
);

    import prc_pkg::*;

    always_comb begin
        o_cmp.start_above = (i_ent_start > i_cur);
        o_cmp.end_le_cur  = (i_ent_end <= i_cur);
        o_cmp.end_lt_stop = (i_ent_end < i_stop);
        o_cmp.marks_ok    = ((i_ent_marks & i_need) == i_need);
    end

endmodule

`default_nettype wire

### rtl/region_permission_checker_unit.sv
`default_nettype none
// Channel   Signals                                         Direction
// command   start, busy, i_cmd, i_region_start/end/marks,   in  (taken on start & !busy)
//           i_query_addr, i_query_len, i_required_marks
// result    o_strobe, o_permitted, o_found, o_found_marks,  out (one cycle, no backpressure)
//           o_dropped
//
// Clear and append strobe their result in the next cycle.
// Check and lookup walk the table one entry per cycle through the shared
// compare unit and the registered read of the table RAM; how long a walk
// lasts is set by the number of entries visited. Refused checks and an
// empty table answer in the next cycle. Synchronous active-low reset empties
// the table; the entries themselves are not cleared. The receiver cannot stall.

module region_permission_checker_unit #(
    parameter int TABLE_DEPTH = prc_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_WIDTH  = prc_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [ADDR_WIDTH-1:0]       i_region_start,
    input  wire logic [ADDR_WIDTH-1:0]       i_region_end,
    input  wire logic [prc_pkg::MARKS_W-1:0] i_region_marks,
    input  wire logic [ADDR_WIDTH-1:0]       i_query_addr,
    input  wire logic [ADDR_WIDTH-1:0]       i_query_len,
    input  wire logic [prc_pkg::MARKS_W-1:0] i_required_marks,
    output logic                             o_strobe,
    output logic                             o_permitted,
    output logic                             o_found,
    output logic [prc_pkg::MARKS_W-1:0]      o_found_marks,
    output logic                             o_dropped
);

    import prc_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 2 * ADDR_WIDTH + MARKS_W;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [IW-1:0]           r_idx, n_idx;
    logic [ADDR_WIDTH-1:0]   r_cur, n_cur;
    logic [ADDR_WIDTH-1:0]   r_stop, n_stop;
    logic [MARKS_W-1:0]      r_need, n_need;
    logic                    r_is_look, n_is_look;
    logic                    r_strobe, n_strobe;
    logic                    r_permitted, n_permitted;
    logic                    r_found, n_found;
    logic [MARKS_W-1:0]      r_found_marks, n_found_marks;
    logic                    r_dropped, n_dropped;

    logic                    wr_en;
    logic [IW-1:0]           rd_addr;
    logic [EW-1:0]           rd_data;
    logic [ADDR_WIDTH-1:0]   ent_start;
    logic [ADDR_WIDTH-1:0]   ent_end;
    logic [MARKS_W-1:0]      ent_marks;
    t_cmp                    cmp;
    logic [ADDR_WIDTH:0]     q_sum;
    logic                    q_refuse;
    logic                    last_ent;

    prc_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({i_region_marks, i_region_end, i_region_start}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign ent_start = rd_data[ADDR_WIDTH-1:0];
    assign ent_end   = rd_data[2*ADDR_WIDTH-1:ADDR_WIDTH];
    assign ent_marks = rd_data[EW-1:2*ADDR_WIDTH];

    prc_cmp #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cmp (
        .i_ent_start (ent_start),
        .i_ent_end   (ent_end),
        .i_ent_marks (ent_marks),
        .i_cur       (r_cur),
        .i_stop      (r_stop),
        .i_need      (r_need),
        .o_cmp       (cmp)
    );

    // prefetch the next entry while the current one is judged
    assign rd_addr  = (r_state == S_WALK) ? (r_idx + IW'(1)) : '0;
    assign last_ent = ((CW'(r_idx) + CW'(1)) == r_count);

    assign q_sum    = {1'b0, i_query_addr} + {1'b0, i_query_len};
    assign q_refuse = (i_query_len == '0) || (i_query_addr == '0) || q_sum[ADDR_WIDTH];

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_cur         = r_cur;
        n_stop        = r_stop;
        n_need        = r_need;
        n_is_look     = r_is_look;
        n_strobe      = 1'b0;
        n_permitted   = r_permitted;
        n_found       = r_found;
        n_found_marks = r_found_marks;
        n_dropped     = r_dropped;
        wr_en         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_strobe      = 1'b1;
                    n_permitted   = 1'b0;
                    n_found       = 1'b0;
                    n_found_marks = '0;
                    n_dropped     = 1'b0;
                    case (t_cmd'(i_cmd))
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_APPEND: begin
                            if (i_region_end > i_region_start) begin
                                if (r_count == CW'(TABLE_DEPTH)) begin
                                    n_dropped = 1'b1;
                                end else begin
                                    wr_en   = 1'b1;
                                    n_count = r_count + CW'(1);
                                end
                            end
                        end
                        CMD_CHECK: begin
                            if (!q_refuse && r_count != '0) begin
                                n_strobe  = 1'b0;
                                n_state   = S_WALK;
                                n_idx     = '0;
                                n_cur     = i_query_addr;
                                n_stop    = q_sum[ADDR_WIDTH-1:0];
                                n_need    = i_required_marks;
                                n_is_look = 1'b0;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (r_count != '0) begin
                                n_strobe  = 1'b0;
                                n_state   = S_WALK;
                                n_idx     = '0;
                                n_cur     = i_query_addr;
                                n_stop    = i_query_addr;
                                n_need    = '0;
                                n_is_look = 1'b1;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_is_look) begin
                    if (!cmp.start_above && !cmp.end_le_cur) begin
                        n_strobe      = 1'b1;
                        n_found       = 1'b1;
                        n_found_marks = ent_marks;
                        n_state       = S_IDLE;
                    end else if (cmp.start_above || last_ent) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else if (!cmp.end_le_cur) begin
                    if (cmp.start_above || !cmp.marks_ok) begin
                        // gap or missing mark: deny
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else if (!cmp.end_lt_stop) begin
                        n_strobe    = 1'b1;
                        n_permitted = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_cur = ent_end;
                        if (last_ent) begin
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end
                end else if (last_ent) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_cur         <= n_cur;
        r_stop        <= n_stop;
        r_need        <= n_need;
        r_is_look     <= n_is_look;
        r_permitted   <= n_permitted;
        r_found       <= n_found;
        r_found_marks <= n_found_marks;
        r_dropped     <= n_dropped;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_permitted   = r_permitted;
    assign o_found       = r_found;
    assign o_found_marks = r_found_marks;
    assign o_dropped     = r_dropped;

endmodule

`default_nettype wire
